// ----- hw/rtl/e2c_pkg.sv -----
// ----------------------------------------------------------------------------
// e2c_pkg: shared types and constants for the epoch to calendar converter
// Sequencer states, subtractor result type and the month length table.
// ----------------------------------------------------------------------------
package e2c_pkg;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned OUT_DATA_W  = 40;
	localparam int unsigned SECS_DAY    = 86400;
	localparam int unsigned SECS_HOUR   = 3600;
	localparam int unsigned SECS_MIN    = 60;
	localparam int unsigned DAYS_COMMON = 365;
	localparam int unsigned FIRST_YEAR  = 1970;
	localparam int unsigned LAST_YEAR   = 2106;
	localparam int unsigned LAST_MONTH  = 12;

	localparam logic [3:0] DAY_STEP_TOP  = 4'd15;
	localparam logic [3:0] HOUR_STEP_TOP = 4'd4;
	localparam logic [3:0] MIN_STEP_TOP  = 4'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAY,
		ST_HOUR,
		ST_MIN,
		ST_YEAR,
		ST_MONTH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic        ge;
		logic [31:0] diff;
	} sub_res_t;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
			4'd2:                                       d = leap ? 5'd29 : 5'd28;
			default:                                    d = 5'd0;
		endcase
		return d;
	endfunction

endpackage

// ----- hw/rtl/epoch_seconds_to_calendar.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to calendar date and time
// Converts a 32-bit epoch count into year, month, day, hour, minute, second.
// ----------------------------------------------------------------------------
// A word is loaded at the accepting edge, then takes 16 restoring steps for the
// day split, 5 for hours, 6 for minutes, one step per year past 1970 plus one
// closing compare (up to 137), 1 to 12 month steps and a finish state that
// loads the result into the output register, waiting there while the last
// result has not yet been taken. The input is ready again once the finish
// state has handed over the result. Every step runs through the single 32-bit
// subtract and compare unit, so the year walk sets the length. The input is not
// ready while a conversion is in progress; the result sits in an output
// register, so the next word may be accepted while it waits. Any year whose two
// low bits are zero is leap, 2100 included.
module epoch_seconds_to_calendar import e2c_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_W-1:0]     s_tdata,  // [31:0] seconds_since_epoch
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // [11:0] year, [15:12] month,
	                                        // [20:16] day_of_month, [25:21] hour,
	                                        // [31:26] minute, [37:32] second_of_minute,
	                                        // [39:38] zero
);

	state_t      state_q, state_d;
	logic [3:0]  cnt_q;
	logic [31:0] acc_q;
	logic [15:0] quot_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic        out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [31:0] operand;
	logic [31:0] acc_next;
	logic        leap;
	sub_res_t    res;

	assign leap = (year_q[1:0] == 2'b00);

	always_comb begin
		unique case (state_q)
			ST_DAY:   operand = 32'(SECS_DAY) << cnt_q;
			ST_HOUR:  operand = 32'(SECS_HOUR) << cnt_q;
			ST_MIN:   operand = 32'(SECS_MIN) << cnt_q;
			ST_YEAR:  operand = leap ? 32'(DAYS_COMMON + 1) : 32'(DAYS_COMMON);
			ST_MONTH: operand = 32'(month_days(month_q, leap));
			default:  operand = '0;
		endcase
	end

	e2c_sub u_sub (
		.a   (acc_q),
		.b   (operand),
		.res (res)
	);

	assign acc_next = res.ge ? res.diff : acc_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_DAY;
			ST_DAY:    if (cnt_q == '0) state_d = ST_HOUR;
			ST_HOUR:   if (cnt_q == '0) state_d = ST_MIN;
			ST_MIN:    if (cnt_q == '0) state_d = ST_YEAR;
			ST_YEAR:   if (!res.ge) state_d = ST_MONTH;
			ST_MONTH:  if (!(month_q < 4'(LAST_MONTH) && res.ge)) state_d = ST_FINISH;
			ST_FINISH: if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			year_q      <= 12'(FIRST_YEAR);
			month_q     <= 4'd1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q   <= DAY_STEP_TOP;
					year_q  <= 12'(FIRST_YEAR);
					month_q <= 4'd1;
				end
				ST_DAY:  cnt_q <= (cnt_q == '0) ? HOUR_STEP_TOP : cnt_q - 4'd1;
				ST_HOUR: cnt_q <= (cnt_q == '0) ? MIN_STEP_TOP : cnt_q - 4'd1;
				ST_MIN:  cnt_q <= (cnt_q == '0) ? '0 : cnt_q - 4'd1;
				ST_YEAR: if (res.ge) year_q <= year_q + 12'd1;
				ST_MONTH: begin
					if (month_q < 4'(LAST_MONTH) && res.ge) month_q <= month_q + 4'd1;
				end
				default: ;
			endcase
			if (state_q == ST_FINISH && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				acc_q    <= s_tdata;
				quot_q   <= '0;
				hour_q   <= '0;
				minute_q <= '0;
			end
			ST_DAY: begin
				acc_q         <= acc_next;
				quot_q[cnt_q] <= res.ge;
			end
			ST_HOUR: begin
				acc_q              <= acc_next;
				hour_q[cnt_q[2:0]] <= res.ge;
			end
			ST_MIN: begin
				minute_q[cnt_q[2:0]] <= res.ge;
				if (cnt_q == '0) begin
					second_q <= acc_next[5:0];
					acc_q    <= {16'd0, quot_q};
				end else begin
					acc_q <= acc_next;
				end
			end
			ST_YEAR: acc_q <= acc_next;
			ST_MONTH: begin
				if (month_q < 4'(LAST_MONTH)) acc_q <= acc_next;
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= {2'b00, second_q, minute_q, hour_q,
						acc_q[4:0] + 5'd1, month_q, year_q};
				end
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		month_q >= 4'd1 && month_q <= 4'(LAST_MONTH))
		else $error("month counter out of range");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		year_q >= 12'(FIRST_YEAR) && year_q <= 12'(LAST_YEAR))
		else $error("year counter out of range");

	a_hour_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HOUR |-> acc_q < 32'(SECS_DAY))
		else $error("day split left remainder too large");

	a_month_days: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MONTH |-> acc_q < 32'(DAYS_COMMON + 1))
		else $error("day count beyond one year in month walk");

	a_finish_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && m_tready |=> m_tvalid && state_q == ST_IDLE)
		else $error("finished result not loaded");

endmodule

// ----- hw/rtl/e2c_sub.sv -----
// ----------------------------------------------------------------------------
// e2c_sub: shared subtract and compare unit
// Gives a minus b and whether a is at least b, for unsigned 32-bit words.
// ----------------------------------------------------------------------------
module e2c_sub import e2c_pkg::*; (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output sub_res_t    res
);

	logic [32:0] wide;

	assign wide     = {1'b0, a} - {1'b0, b};
	assign res.ge   = ~wide[32];
	assign res.diff = wide[31:0];

endmodule
